>>> hw/rtl/mhc_pkg.sv
package mhc_pkg;

    // Working widths. X and Y carry the 16-bit sample scaled by 2^8, a sign,
    // and headroom for the CORDIC gain (about 1.65) and the 180 degree pre-rotation.
    localparam int XY_W      = 28;
    // The angle accumulator holds degrees times 2^16, signed, within -100..+281 degrees.
    localparam int Z_W       = 26;
    localparam int ACC_FRAC  = 16;
    localparam int TABLE_LEN = 24;
    localparam int HEAD_W    = 15;

    localparam int CORDIC_STEPS_DEF        = 16;
    localparam int ANGLE_FRACTION_BITS_DEF = 6;

    localparam logic signed [Z_W-1:0] DEG180 = 26'sd11796480;
    localparam logic signed [Z_W-1:0] DEG360 = 26'sd23592960;

    typedef struct packed {
        logic                   zero;
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [Z_W-1:0]  z;
    } t_cdata;

    // atan(2^-i) in degrees times 2^16, rounded to nearest.
    function automatic logic signed [Z_W-1:0] atan_deg(input int step);
        logic signed [Z_W-1:0] v;
        case (step)
            0:       v = 26'sd2949120;
            1:       v = 26'sd1740967;
            2:       v = 26'sd919879;
            3:       v = 26'sd466945;
            4:       v = 26'sd234379;
            5:       v = 26'sd117304;
            6:       v = 26'sd58671;
            7:       v = 26'sd29335;
            8:       v = 26'sd14668;
            9:       v = 26'sd7334;
            10:      v = 26'sd3667;
            11:      v = 26'sd1833;
            12:      v = 26'sd917;
            13:      v = 26'sd458;
            14:      v = 26'sd229;
            15:      v = 26'sd115;
            16:      v = 26'sd57;
            17:      v = 26'sd29;
            18:      v = 26'sd14;
            19:      v = 26'sd7;
            20:      v = 26'sd4;
            21:      v = 26'sd2;
            22:      v = 26'sd1;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

>>> hw/rtl/mhc_prep.sv
module mhc_prep (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  logic [7:0]      i_x_low_byte,
    input  logic [7:0]      i_x_high_byte,
    input  logic [7:0]      i_y_low_byte,
    input  logic [7:0]      i_y_high_byte,
    output logic            o_valid,
    output mhc_pkg::t_cdata o_data
);
    import mhc_pkg::*;

    logic signed [XY_W-1:0] x_sc;
    logic signed [XY_W-1:0] y_sc;
    logic                   r_valid;
    t_cdata                 r_data;
    t_cdata                 n_data;

    // Sign-extend the assembled 16-bit samples and scale them by 2^8.
    assign x_sc = {{(XY_W-24){i_x_high_byte[7]}}, i_x_high_byte, i_x_low_byte, 8'd0};
    assign y_sc = {{(XY_W-24){i_y_high_byte[7]}}, i_y_high_byte, i_y_low_byte, 8'd0};

    // A vector in the left half plane is turned by 180 degrees first.
    always_comb begin
        n_data.zero = (x_sc == '0) && (y_sc == '0);
        if (x_sc[XY_W-1]) begin
            n_data.x = -x_sc;
            n_data.y = -y_sc;
            n_data.z = DEG180;
        end else begin
            n_data.x = x_sc;
            n_data.y = y_sc;
            n_data.z = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

>>> hw/rtl/mhc_cell.sv
module mhc_cell #(
    parameter int STEP = 0
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  mhc_pkg::t_cdata i_data,
    output logic            o_valid,
    output mhc_pkg::t_cdata o_data
);
    import mhc_pkg::*;

    localparam logic signed [Z_W-1:0] ANGLE = atan_deg(STEP);

    logic signed [XY_W-1:0] dx;
    logic signed [XY_W-1:0] dy;
    logic                   r_valid;
    t_cdata                 r_data;
    t_cdata                 n_data;

    assign dx = i_data.y >>> STEP;
    assign dy = i_data.x >>> STEP;

    // Rotate toward the X axis: the sign of Y picks the direction.
    always_comb begin
        n_data.zero = i_data.zero;
        if (!i_data.y[XY_W-1]) begin
            n_data.x = i_data.x + dx;
            n_data.y = i_data.y - dy;
            n_data.z = i_data.z + ANGLE;
        end else begin
            n_data.x = i_data.x - dx;
            n_data.y = i_data.y + dy;
            n_data.z = i_data.z - ANGLE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

>>> hw/rtl/mhc_round.sv
module mhc_round #(
    parameter int ANGLE_FRACTION_BITS = mhc_pkg::ANGLE_FRACTION_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    input  mhc_pkg::t_cdata           i_data,
    output logic                      o_valid,
    output logic [mhc_pkg::HEAD_W-1:0] o_heading
);
    import mhc_pkg::*;

    localparam int             DROP  = ACC_FRAC - ANGLE_FRACTION_BITS;
    localparam logic [Z_W-1:0] HALF  = Z_W'(1) << (DROP - 1);
    localparam logic [Z_W-1:0] LIMIT = Z_W'(360) << ANGLE_FRACTION_BITS;

    logic signed [Z_W-1:0] z_wrap;
    logic [Z_W-1:0]        sum;
    logic [Z_W-1:0]        res;
    logic [HEAD_W-1:0]     n_heading;
    logic                  r_valid_a;
    logic                  r_zero_a;
    logic [Z_W-2:0]        r_z_a;
    logic                  r_valid_b;
    logic [HEAD_W-1:0]     r_heading;

    // First stage: bring the angle into 0 to 360 degrees.
    always_comb begin
        if (i_data.z[Z_W-1]) begin
            z_wrap = i_data.z + DEG360;
        end else if (i_data.z >= DEG360) begin
            z_wrap = i_data.z - DEG360;
        end else begin
            z_wrap = i_data.z;
        end
    end

    // Second stage: round half up, fold a full turn back to zero, force zero for a zero vector.
    always_comb begin
        sum = {1'b0, r_z_a} + HALF;
        res = sum >> DROP;
        if (r_zero_a || (res >= LIMIT)) begin
            n_heading = '0;
        end else begin
            n_heading = res[HEAD_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid_a <= 1'b0;
            r_valid_b <= 1'b0;
        end else begin
            r_valid_a <= i_valid;
            r_valid_b <= r_valid_a;
        end
    end

    always_ff @(posedge i_clk) begin
        r_zero_a  <= i_data.zero;
        r_z_a     <= z_wrap[Z_W-2:0];
        r_heading <= n_heading;
    end

    assign o_valid   = r_valid_b;
    assign o_heading = r_heading;

endmodule

>>> hw/rtl/magnetometer_heading_cordic_unit.sv
// Compass heading from a pair of magnetometer samples.
//
// A sample beat is offered by raising start with the four byte ports set;
// it is taken at the rising edge where start is high and busy is low. X and
// Y are each assembled from a little-endian byte pair as signed 16-bit values.
// busy never rises: the datapath is a fixed pipeline and takes a new beat
// in every cycle, so the sustained rate is one sample per clock.
// The heading atan2(Y, X) in degrees, within 0 up to just below 360, appears
// on o_heading_angle as unsigned fixed point with ANGLE_FRACTION_BITS fraction
// bits, for exactly one cycle marked by o_valid. A beat passes one input
// cell, one cell per CORDIC iteration and two output cells (wrap, round).
// Beats leave in the order they came. The receiver cannot hold results off
// and none is needed, since nothing is ever queued.
// A synchronous reset (i_rst_n low) drops every beat in flight; no
// result appears for them. There is no configuration and no stored state.
module magnetometer_heading_cordic_unit #(
    parameter int CORDIC_STEPS        = mhc_pkg::CORDIC_STEPS_DEF,
    parameter int ANGLE_FRACTION_BITS = mhc_pkg::ANGLE_FRACTION_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [7:0]                 i_x_low_byte,
    input  logic [7:0]                 i_x_high_byte,
    input  logic [7:0]                 i_y_low_byte,
    input  logic [7:0]                 i_y_high_byte,
    output logic                       o_valid,
    output logic [mhc_pkg::HEAD_W-1:0] o_heading_angle
);
    import mhc_pkg::*;

    // Only the iterations with an arctangent table entry exist.
    localparam int N_CELLS = (CORDIC_STEPS < TABLE_LEN) ? CORDIC_STEPS : TABLE_LEN;
    localparam int LATENCY = N_CELLS + 3;
    // Highest legal heading plus one; with wide fractions the port masks it.
    localparam logic [Z_W-1:0] HEAD_LIMIT = (ANGLE_FRACTION_BITS <= 6) ?
        (Z_W'(360) << ANGLE_FRACTION_BITS) : (Z_W'(1) << HEAD_W);

    logic   chain_valid [N_CELLS+1];
    t_cdata chain_data  [N_CELLS+1];

    // The pipeline never stalls, so a beat is always welcome.
    assign busy = 1'b0;

    // The input cell assembles the samples and pre-rotates the left half plane.
    mhc_prep u_prep (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (start),
        .i_x_low_byte  (i_x_low_byte),
        .i_x_high_byte (i_x_high_byte),
        .i_y_low_byte  (i_y_low_byte),
        .i_y_high_byte (i_y_high_byte),
        .o_valid       (chain_valid[0]),
        .o_data        (chain_data[0])
    );

    // Row of vectoring cells; cell s shifts by s and adds or subtracts atan(2^-s).
    for (genvar s = 0; s < N_CELLS; s++) begin : g_cell
        mhc_cell #(
            .STEP (s)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (chain_valid[s]),
            .i_data  (chain_data[s]),
            .o_valid (chain_valid[s+1]),
            .o_data  (chain_data[s+1])
        );
    end

    // Output cells wrap the angle into one full turn, then round to the
    // requested fraction. A sample with both axes zero reads as heading zero.
    mhc_round #(
        .ANGLE_FRACTION_BITS (ANGLE_FRACTION_BITS)
    ) u_round (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (chain_valid[N_CELLS]),
        .i_data    (chain_data[N_CELLS]),
        .o_valid   (o_valid),
        .o_heading (o_heading_angle)
    );

    // Every accepted beat comes out as a result on o_valid.
    a_beat_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start |-> ##LATENCY o_valid)
        else $error("accepted beat did not produce a result on time");

    // No result appears without an accepted beat.
    a_no_ghost: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !start |-> ##LATENCY !o_valid)
        else $error("result strobe without a matching input beat");

    // A sample with both axes zero must report heading zero.
    a_zero_vec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && (i_x_low_byte == 8'd0) && (i_x_high_byte == 8'd0) &&
         (i_y_low_byte == 8'd0) && (i_y_high_byte == 8'd0))
        |-> ##LATENCY (o_heading_angle == '0))
        else $error("zero vector gave a nonzero heading");

    // A reported heading stays below HEAD_LIMIT, a full turn where the port can show it.
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ({{(Z_W-HEAD_W){1'b0}}, o_heading_angle} < HEAD_LIMIT))
        else $error("heading out of range");

endmodule

>>> tb/testbench.sv
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import mhc_pkg::*;

    // The block runs with its default configuration. The predictor below uses
    // the same two values.
    localparam int STEPS     = CORDIC_STEPS_DEF;
    localparam int FRAC_BITS = ANGLE_FRACTION_BITS_DEF;

    // Edges from the accepting edge to the edge that takes the heading.
    localparam int LATENCY = STEPS + 3;

    // The limit is a generous multiple of the longest idle stretch that the sender
    // makes plus the pipeline depth.
    localparam int WATCHDOG_LIMIT = 1000;

    localparam int RANDOM_ITEMS = 2000;

    // The arctangent table: atan(2^-i) in degrees, scaled by 2^16 and rounded
    // to nearest. Only 24 entries exist, so the iteration count is capped at 24.
    localparam int ATAN_ENTRIES = 24;
    localparam longint ATAN_TBL [0:ATAN_ENTRIES-1] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58671, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115,
        57, 29, 14, 7, 4, 2, 1, 0
    };

    localparam longint HALF_TURN = longint'(180) * 65536;
    localparam longint FULL_TURN = longint'(360) * 65536;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              start = 1'b0;
    logic              busy;
    logic [7:0]        i_x_low_byte = '0;
    logic [7:0]        i_x_high_byte = '0;
    logic [7:0]        i_y_low_byte = '0;
    logic [7:0]        i_y_high_byte = '0;
    logic              o_valid;
    logic [HEAD_W-1:0] o_heading_angle;

    // Headings still owed by the block, oldest first.
    logic [HEAD_W-1:0] heading_q [$];

    int mismatch_count = 0;
    int idle_cycles = 0;

    always #5 i_clk = ~i_clk;

    magnetometer_heading_cordic_unit #(
        .CORDIC_STEPS        (STEPS),
        .ANGLE_FRACTION_BITS (FRAC_BITS)
    ) u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_x_low_byte    (i_x_low_byte),
        .i_x_high_byte   (i_x_high_byte),
        .i_y_low_byte    (i_y_low_byte),
        .i_y_high_byte   (i_y_high_byte),
        .o_valid         (o_valid),
        .o_heading_angle (o_heading_angle)
    );

    // Heading of one sample pair, computed the way the hardware is specified:
    // a vectoring CORDIC on X and Y scaled by 2^8, with the angle kept in
    // degrees times 2^16. Right shifts on the signed 64-bit working values are
    // arithmetic, which rounds toward minus infinity as required.
    function automatic logic [HEAD_W-1:0] predict_heading(
        input logic [7:0] x_lo, input logic [7:0] x_hi,
        input logic [7:0] y_lo, input logic [7:0] y_hi
    );
        logic signed [15:0] x_raw;
        logic signed [15:0] y_raw;
        longint             x;
        longint             y;
        longint             z;
        longint             dx;
        longint             dy;
        longint unsigned    angle;
        int                 drop;
        x_raw = {x_hi, x_lo};
        y_raw = {y_hi, y_lo};
        x = x_raw;
        y = y_raw;
        z = 0;
        drop = ACC_FRAC - FRAC_BITS;

        // A vector of length zero has no direction; the block reports north.
        if (x == 0 && y == 0) begin
            return '0;
        end

        x = x * 256;
        y = y * 256;

        // Vectors in the left half plane are turned by half a circle first, so
        // the iterations only ever see X >= 0.
        if (x < 0) begin
            x = -x;
            y = -y;
            z = HALF_TURN;
        end

        for (int i = 0; i < STEPS && i < ATAN_ENTRIES; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0) begin
                x = x + dx;
                y = y - dy;
                z = z + ATAN_TBL[i];
            end else begin
                x = x - dx;
                y = y + dy;
                z = z - ATAN_TBL[i];
            end
        end

        // Wrap into one turn, then round half up to the output resolution.
        if (z < 0) begin
            z = z + FULL_TURN;
        end
        if (z >= FULL_TURN) begin
            z = z - FULL_TURN;
        end
        if (drop > 0) begin
            angle = (longint'(z) + (longint'(1) << (drop - 1))) >> drop;
        end else begin
            angle = z;
        end
        // Rounding just below a full turn lands on 360 degrees, which is north.
        if (angle >= (longint'(360) << FRAC_BITS)) begin
            angle = 0;
        end
        return angle[HEAD_W-1:0];
    endfunction

    // Offers one sample beat and returns at the edge that accepts it. Start is
    // left high, so a following beat can go out in the very next cycle.
    task automatic send_sample(
        input logic [7:0] x_lo, input logic [7:0] x_hi,
        input logic [7:0] y_lo, input logic [7:0] y_hi
    );
        start         <= 1'b1;
        i_x_low_byte  <= x_lo;
        i_x_high_byte <= x_hi;
        i_y_low_byte  <= y_lo;
        i_y_high_byte <= y_hi;
        @(posedge i_clk);
        // busy is read before the edge updates it, so this is the value that
        // the block itself saw at this edge.
        while (busy) begin
            @(posedge i_clk);
        end
        heading_q.push_back(predict_heading(x_lo, x_hi, y_lo, y_hi));
    endtask

    task automatic send_xy(input logic [15:0] x, input logic [15:0] y);
        send_sample(x[7:0], x[15:8], y[7:0], y[15:8]);
    endtask

    // Lowers start for a random number of cycles. Most gaps are empty or
    // short, a few are long. With no gap, start simply stays high.
    task automatic sender_gap();
        int pick;
        int cycles;
        pick = $urandom_range(0, 99);
        if (pick < 50) begin
            cycles = 0;
        end else if (pick < 85) begin
            cycles = $urandom_range(1, 3);
        end else if (pick < 97) begin
            cycles = $urandom_range(4, 12);
        end else begin
            cycles = $urandom_range(20, 60);
        end
        if (cycles > 0) begin
            start <= 1'b0;
            repeat (cycles) @(posedge i_clk);
        end
    endtask

    // The zero vector and the four compass points, at the smallest and the
    // largest magnitudes.
    task automatic test_axes();
        send_xy(16'sd0, 16'sd0);          sender_gap();
        send_xy(16'sd1, 16'sd0);          sender_gap();
        send_xy(16'sd0, 16'sd1);          sender_gap();
        send_xy(-16'sd1, 16'sd0);         sender_gap();
        send_xy(16'sd0, -16'sd1);         sender_gap();
        send_xy(16'sd32767, 16'sd0);      sender_gap();
        send_xy(-16'sd32768, 16'sd0);     sender_gap();
        send_xy(16'sd0, 16'sd32767);      sender_gap();
        send_xy(16'sd0, -16'sd32768);     sender_gap();
    endtask

    // Full-scale corners, unit diagonals and byte patterns that put all ones
    // in one byte and all zeros in the other.
    task automatic test_extremes();
        send_xy(16'sd32767, 16'sd32767);    sender_gap();
        send_xy(-16'sd32768, -16'sd32768);  sender_gap();
        send_xy(-16'sd32768, 16'sd32767);   sender_gap();
        send_xy(16'sd32767, -16'sd32768);   sender_gap();
        send_xy(16'sd1, 16'sd1);            sender_gap();
        send_xy(-16'sd1, -16'sd1);          sender_gap();
        send_xy(16'sd1, -16'sd1);           sender_gap();
        send_xy(-16'sd1, 16'sd1);           sender_gap();
        send_sample(8'hFF, 8'h00, 8'h00, 8'hFF);  sender_gap();
        send_sample(8'h00, 8'hFF, 8'hFF, 8'h00);  sender_gap();
    endtask

    // Vectors just below the positive X axis give a heading a hair under a
    // full turn, which must round to north. Vectors next to the negative X
    // axis check the half-turn pre-rotation from both sides.
    task automatic test_wrap_points();
        send_xy(16'sd32767, -16'sd1);     sender_gap();
        send_xy(16'sd20000, -16'sd1);     sender_gap();
        send_xy(-16'sd32768, 16'sd1);     sender_gap();
        send_xy(-16'sd32768, -16'sd1);    sender_gap();
    endtask

    // Random samples of four shapes: raw random bytes, small vectors where
    // the shifts quickly run to zero or minus one, vectors close to an axis,
    // and exact diagonals. Now and then a burst of beats goes back to back.
    task automatic test_random_samples(input int count);
        int          shape;
        int          burst_left;
        int          a;
        int          b;
        logic [15:0] x;
        logic [15:0] y;
        burst_left = 0;
        for (int n = 0; n < count; n++) begin
            shape = $urandom_range(0, 99);
            if (shape < 40) begin
                send_sample(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
            end else begin
                if (shape < 70) begin
                    x = 16'($signed($urandom_range(0, 64)) - 32);
                    y = 16'($signed($urandom_range(0, 64)) - 32);
                end else if (shape < 85) begin
                    a = $urandom_range(0, 65535);
                    b = int'($urandom_range(0, 8)) - 4;
                    if ($urandom_range(0, 1) == 1) begin
                        x = 16'(a);
                        y = 16'(b);
                    end else begin
                        x = 16'(b);
                        y = 16'(a);
                    end
                end else begin
                    a = $urandom_range(1, 32767);
                    x = $urandom_range(0, 1) == 1 ? 16'(a) : 16'(-a);
                    y = $urandom_range(0, 1) == 1 ? 16'(a) : 16'(-a);
                end
                send_xy(x, y);
            end

            if (burst_left > 0) begin
                burst_left--;
            end else if ($urandom_range(0, 99) < 3) begin
                burst_left = $urandom_range(20, 80);
            end else begin
                sender_gap();
            end
        end
    endtask

    // Each heading strobe is taken at the edge that ends its cycle and is
    // checked against the oldest heading still owed.
    always @(posedge i_clk) begin
        logic [HEAD_W-1:0] want;
        if (i_rst_n && o_valid) begin
            if (heading_q.size() == 0) begin
                $display("%0t: unexpected heading beat, expected none, actual %0d",
                         $time, o_heading_angle);
                mismatch_count++;
            end else begin
                want = heading_q.pop_front();
                if (o_heading_angle !== want) begin
                    $display("%0t: heading mismatch, expected %0d, actual %0d",
                             $time, want, o_heading_angle);
                    mismatch_count++;
                end
            end
        end
    end

    // Ends the run when neither side has moved a beat for too long.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((start && !busy) || o_valid) begin
                idle_cycles <= 0;
            end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
                $display("%0t: no beat moved for %0d cycles", $time, WATCHDOG_LIMIT);
                $display("CHECK FAILED");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_axes();
        test_extremes();
        test_wrap_points();
        test_random_samples(RANDOM_ITEMS);

        // Drain: wait for every owed heading, then a little longer to catch a
        // stray strobe.
        start <= 1'b0;
        while (heading_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (LATENCY + 4) @(posedge i_clk);

        if (heading_q.size() != 0) begin
            $display("%0t: %0d headings never arrived", $time, heading_q.size());
            mismatch_count++;
        end

        if (mismatch_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
